/* hdl/tpi_pkg.sv */
// Shared types and widths for the three-plane intersection pipeline.
package tpi_pkg;

  localparam int NW    = 16;
  localparam int DW    = 32;
  localparam int CW    = 34;          // cross product component
  localparam int DETW  = 51;          // determinant, signed
  localparam int ADW   = 50;          // determinant magnitude
  localparam int THRW  = 43;
  localparam int NUMW  = 68;          // numerator, signed
  localparam int MAGW  = 67;          // numerator magnitude
  localparam int DIVW  = MAGW + 14;   // shifted dividend bits
  localparam int QW    = 34;          // kept quotient bits (32 + guard)
  localparam int RW    = ADW + 1;     // remainder width

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic                  vld;
    logic                  degen;
    logic                  dneg;
  } ctl_t;

endpackage

/* hdl/three_plane_intersection_top.sv */
// Top level of the three-plane intersection pipeline.
// Usage:
//   Drive the twelve plane fields with start_i high for one cycle to issue a
//   word. busy_o is always low: a new word may enter on every clock.
//   Each word yields exactly one result, shown for one cycle with done_o high
//   and accepted at the edge ending that cycle; the receiver cannot stall.
//   The pipeline has 5 + 81 + 1 = 87 register stages: five multiply and sum
//   stages, then a divider with one register stage per dividend bit
//   (81 bits: 67-bit numerator magnitude shifted by 14), then the output
//   register.
//   Throughput is one word per cycle; three dividers run in
//   parallel, one per coordinate.
//   Degenerate words (|det| below det_threshold, or zero) give zero
//   coordinates with point_valid_o and point_saturated_o low.
//   cfg_we_i writes det_threshold from cfg_wdata_i; write it only while idle.
//   Reset clears the pipeline valid bits and done_o (not point_valid_o) and loads det_threshold with its default.
module three_plane_intersection_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [15:0]  plane_a_normal_x_i,
  input  logic signed [15:0]  plane_a_normal_y_i,
  input  logic signed [15:0]  plane_a_normal_z_i,
  input  logic signed [31:0]  plane_a_dist_i,
  input  logic signed [15:0]  plane_b_normal_x_i,
  input  logic signed [15:0]  plane_b_normal_y_i,
  input  logic signed [15:0]  plane_b_normal_z_i,
  input  logic signed [31:0]  plane_b_dist_i,
  input  logic signed [15:0]  plane_c_normal_x_i,
  input  logic signed [15:0]  plane_c_normal_y_i,
  input  logic signed [15:0]  plane_c_normal_z_i,
  input  logic signed [31:0]  plane_c_dist_i,
  input  logic                cfg_we_i,
  input  logic [42:0]         cfg_wdata_i,
  output logic                done_o,
  output logic signed [31:0]  point_x_o,
  output logic signed [31:0]  point_y_o,
  output logic signed [31:0]  point_z_o,
  output logic                point_valid_o,
  output logic                point_saturated_o
);

  logic [tpi_pkg::THRW-1:0] thr_q;
  tpi_pkg::vec_t            na, nb, nc;
  tpi_pkg::ctl_t            ctl;
  logic [tpi_pkg::ADW-1:0]  aden;
  logic [tpi_pkg::MAGW-1:0] mag [3];
  logic [2:0]               nneg, dv, dp, ds;
  logic signed [31:0]       q [3];
  logic                     done_q, pv_q, ps_q;
  logic signed [31:0]       px_q, py_q, pz_q;

  assign busy_o = 1'b0;
  assign na = '{x: plane_a_normal_x_i, y: plane_a_normal_y_i, z: plane_a_normal_z_i};
  assign nb = '{x: plane_b_normal_x_i, y: plane_b_normal_y_i, z: plane_b_normal_z_i};
  assign nc = '{x: plane_c_normal_x_i, y: plane_c_normal_y_i, z: plane_c_normal_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tpi_pkg::THRW'(43'd4398047);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  tpi_geom u_geom (
    .clk_i, .rst_ni, .vld_i(start_i),
    .na_i(na), .nb_i(nb), .nc_i(nc),
    .da_i(plane_a_dist_i), .db_i(plane_b_dist_i), .dc_i(plane_c_dist_i),
    .thr_i(thr_q), .ctl_o(ctl), .aden_o(aden), .mag_o(mag), .nneg_o(nneg)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    tpi_div u_div (
      .clk_i, .rst_ni, .vld_i(ctl.vld), .pass_i(!ctl.degen),
      .neg_i(nneg[k] ^ ctl.dneg), .mag_i(mag[k]),
      .den_i(ctl.degen ? tpi_pkg::ADW'(1) : aden),
      .vld_o(dv[k]), .pass_o(dp[k]), .q_o(q[k]), .sat_o(ds[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= dp[0];
    ps_q <= dp[0] & (|ds);
    px_q <= dp[0] ? q[0] : '0;
    py_q <= dp[0] ? q[1] : '0;
    pz_q <= dp[0] ? q[2] : '0;
  end

  assign done_o            = done_q;
  assign point_x_o         = px_q;
  assign point_y_o         = py_q;
  assign point_z_o         = pz_q;
  assign point_valid_o     = pv_q;
  assign point_saturated_o = ps_q;

  a_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[0] == dv[1] && dv[1] == dv[2]) else $error("divider lanes out of step");
  a_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !point_valid_o |-> !point_saturated_o && point_x_o == 0)
    else $error("degenerate result not cleared");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("pipeline stalled");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[0] |=> done_o) else $error("lost result");

endmodule

/* hdl/tpi_geom.sv */
// Cross products, determinant and numerators over five register stages.
module tpi_geom (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  tpi_pkg::vec_t                 na_i,
  input  tpi_pkg::vec_t                 nb_i,
  input  tpi_pkg::vec_t                 nc_i,
  input  logic signed [tpi_pkg::DW-1:0] da_i,
  input  logic signed [tpi_pkg::DW-1:0] db_i,
  input  logic signed [tpi_pkg::DW-1:0] dc_i,
  input  logic [tpi_pkg::THRW-1:0]      thr_i,
  output tpi_pkg::ctl_t                 ctl_o,
  output logic [tpi_pkg::ADW-1:0]       aden_o,
  output logic [tpi_pkg::MAGW-1:0]      mag_o [3],
  output logic [2:0]                    nneg_o
);

  localparam int CW   = tpi_pkg::CW;
  localparam int PW   = CW + tpi_pkg::DW;
  localparam int NW_L = tpi_pkg::NW;

  // stage 1: products for cross terms
  logic signed [31:0] pa_q [3][3], pb_q [3][3];
  logic                v1_q, v2_q, v3_q;
  tpi_pkg::vec_t       n1a_q, n2a_q;
  logic signed [tpi_pkg::DW-1:0] d1_q [3], d2_q [3];
  // stage 2: cross components
  logic signed [CW-1:0] c2_q [3][3];
  // stage 3: determinant products, numerator products
  logic signed [PW-1:0] cp_q [3][3];
  logic signed [47:0]   dp_q [3];

  logic signed [NW_L-1:0] n [3][3];

  always_comb begin
    n[0][0] = na_i.x; n[0][1] = na_i.y; n[0][2] = na_i.z;
    n[1][0] = nb_i.x; n[1][1] = nb_i.y; n[1][2] = nb_i.z;
    n[2][0] = nc_i.x; n[2][1] = nc_i.y; n[2][2] = nc_i.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[p][k] <= n[(p+1)%3][(k+1)%3] * n[(p+2)%3][(k+2)%3];
        pb_q[p][k] <= n[(p+1)%3][(k+2)%3] * n[(p+2)%3][(k+1)%3];
      end
    end
    n1a_q   <= na_i;
    d1_q[0] <= da_i; d1_q[1] <= db_i; d1_q[2] <= dc_i;
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        c2_q[p][k] <= CW'(pa_q[p][k]) - CW'(pb_q[p][k]);
      end
    end
    n2a_q   <= n1a_q;
    d2_q    <= d1_q;
    dp_q[0] <= 48'(n2a_q.x) * 48'(c2_q[0][0]);
    dp_q[1] <= 48'(n2a_q.y) * 48'(c2_q[0][1]);
    dp_q[2] <= 48'(n2a_q.z) * 48'(c2_q[0][2]);
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        cp_q[p][k] <= PW'(c2_q[p][k]) * PW'(d2_q[p]);
      end
    end
  end

  // stage 4: sums; stage 5: magnitude, threshold compare
  logic signed [tpi_pkg::DETW-1:0] det_q;
  logic signed [tpi_pkg::NUMW-1:0] num_q [3];
  logic signed [tpi_pkg::DETW-1:0] det_d;
  logic signed [tpi_pkg::NUMW-1:0] num_d [3];
  logic [tpi_pkg::ADW-1:0]         aden_d;
  logic                            vld_q, degen_q, dneg_q;
  logic [tpi_pkg::ADW-1:0]         aden_q;
  logic [tpi_pkg::MAGW-1:0]        mag_q [3];
  logic [2:0]                      nneg_q;
  logic                            v4_q;

  always_ff @(posedge clk_i) begin
    det_q <= tpi_pkg::DETW'(dp_q[0]) + tpi_pkg::DETW'(dp_q[1])
           + tpi_pkg::DETW'(dp_q[2]);
    for (int k = 0; k < 3; k++) begin
      num_q[k] <= tpi_pkg::NUMW'(cp_q[0][k]) + tpi_pkg::NUMW'(cp_q[1][k])
                + tpi_pkg::NUMW'(cp_q[2][k]);
    end
  end

  always_comb begin
    det_d  = det_q;
    num_d  = num_q;
    aden_d = det_d[tpi_pkg::DETW-1] ? tpi_pkg::ADW'(-det_d) : tpi_pkg::ADW'(det_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q  <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      v4_q  <= v3_q;
      vld_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    degen_q <= (aden_d == '0) || (aden_d < tpi_pkg::ADW'(thr_i));
    dneg_q  <= det_d[tpi_pkg::DETW-1];
    aden_q  <= aden_d;
    for (int k = 0; k < 3; k++) begin
      nneg_q[k] <= num_d[k][tpi_pkg::NUMW-1];
      mag_q[k]  <= num_d[k][tpi_pkg::NUMW-1] ? tpi_pkg::MAGW'(-num_d[k])
                                             : tpi_pkg::MAGW'(num_d[k]);
    end
  end

  assign ctl_o  = '{vld: vld_q, degen: degen_q, dneg: dneg_q};
  assign aden_o = aden_q;
  assign mag_o  = mag_q;
  assign nneg_o = nneg_q;

endmodule

/* hdl/tpi_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module tpi_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic                       pass_i,
  input  logic                       neg_i,
  input  logic [tpi_pkg::MAGW-1:0]   mag_i,
  input  logic [tpi_pkg::ADW-1:0]    den_i,
  output logic                       vld_o,
  output logic                       pass_o,
  output logic signed [31:0]         q_o,
  output logic                       sat_o
);

  localparam int DIVW = tpi_pkg::DIVW;
  localparam int RW   = tpi_pkg::RW;
  localparam int NS   = DIVW;

  // Full dividend bits processed; high bits accumulate an overflow flag.
  logic [DIVW-1:0]         dv_q [1:NS];
  logic [RW-1:0]           r_q  [1:NS];
  logic [tpi_pkg::QW-1:0]  q_q  [1:NS];
  logic                    ov_q [1:NS];
  logic [tpi_pkg::ADW-1:0] dn_q [1:NS];
  logic                    v_q  [1:NS];
  logic                    p_q  [1:NS];
  logic                    n_q  [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [DIVW-1:0]         dv_s;
    logic [RW-1:0]           r_s;
    logic [tpi_pkg::QW-1:0]  q_s;
    logic                    ov_s, v_s, p_s, n_s;
    logic [tpi_pkg::ADW-1:0] dn_s;
    logic [RW-1:0]           sh, df;
    logic                    ge;
    if (s == 0) begin : g_in
      assign dv_s = {mag_i, 14'b0};
      assign r_s  = '0;
      assign q_s  = '0;
      assign ov_s = 1'b0;
      assign dn_s = den_i;
      assign v_s  = vld_i;
      assign p_s  = pass_i;
      assign n_s  = neg_i;
    end else begin : g_mid
      assign dv_s = dv_q[s];
      assign r_s  = r_q[s];
      assign q_s  = q_q[s];
      assign ov_s = ov_q[s];
      assign dn_s = dn_q[s];
      assign v_s  = v_q[s];
      assign p_s  = p_q[s];
      assign n_s  = n_q[s];
    end
    assign sh = {r_s[RW-2:0], dv_s[DIVW-1]};
    assign ge = sh >= RW'(dn_s);
    assign df = ge ? sh - RW'(dn_s) : sh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_s;
      end
    end
    always_ff @(posedge clk_i) begin
      dv_q[s+1] <= dv_s << 1;
      r_q[s+1]  <= df;
      q_q[s+1]  <= {q_s[tpi_pkg::QW-2:0], ge};
      ov_q[s+1] <= ov_s | q_s[tpi_pkg::QW-1];
      dn_q[s+1] <= dn_s;
      p_q[s+1]  <= p_s;
      n_q[s+1]  <= n_s;
    end
  end

  logic [tpi_pkg::QW-1:0] qf;
  logic                   big;
  assign qf  = q_q[NS];
  assign big = ov_q[NS] | q_q[NS][tpi_pkg::QW-1];

  always_comb begin
    sat_o = 1'b0;
    if (n_q[NS]) begin
      if (big || qf > tpi_pkg::QW'(34'h080000000)) begin
        sat_o = 1'b1;
        q_o   = 32'sh80000000;
      end else begin
        q_o = 32'(-qf);
      end
    end else if (big || qf > tpi_pkg::QW'(34'h07fffffff)) begin
      sat_o = 1'b1;
      q_o   = 32'sh7fffffff;
    end else begin
      q_o = 32'(qf);
    end
  end

  assign vld_o  = v_q[NS];
  assign pass_o = p_q[NS];

endmodule

/* verif/tb_three_plane_intersection_top.sv */
// Testbench for three_plane_intersection_top: directed and random plane triples checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_three_plane_intersection_top;

  localparam int          LATENCY   = 87;
  localparam logic [42:0] THR_RESET = 43'd4398047;
  localparam logic [42:0] THR_ALL   = {43{1'b1}};

  typedef struct packed {
    logic [8:0][15:0] nrm;   // plane p, axis k at index p*3+k
    logic [2:0][31:0] dst;
  } planes_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               valid;
    logic               sat;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [15:0] nrm_drv [9];
  logic signed [31:0] dst_drv [3];
  logic cfg_we_i = 1'b0;
  logic [42:0] cfg_wdata_i = '0;
  logic done_o;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;
  logic point_valid_o, point_saturated_o;

  logic [42:0] thr_model = THR_RESET;
  point_t      point_q[$];
  int          mismatches = 0;
  bit          idle_en = 1'b1;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < 9; i++) nrm_drv[i] = '0;
    for (int i = 0; i < 3; i++) dst_drv[i] = '0;
  end

  three_plane_intersection_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .plane_a_normal_x_i (nrm_drv[0]),
    .plane_a_normal_y_i (nrm_drv[1]),
    .plane_a_normal_z_i (nrm_drv[2]),
    .plane_a_dist_i     (dst_drv[0]),
    .plane_b_normal_x_i (nrm_drv[3]),
    .plane_b_normal_y_i (nrm_drv[4]),
    .plane_b_normal_z_i (nrm_drv[5]),
    .plane_b_dist_i     (dst_drv[1]),
    .plane_c_normal_x_i (nrm_drv[6]),
    .plane_c_normal_y_i (nrm_drv[7]),
    .plane_c_normal_z_i (nrm_drv[8]),
    .plane_c_dist_i     (dst_drv[2]),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .point_x_o          (point_x_o),
    .point_y_o          (point_y_o),
    .point_z_o          (point_z_o),
    .point_valid_o      (point_valid_o),
    .point_saturated_o  (point_saturated_o)
  );

  function automatic point_t solve_planes(planes_t w, logic [42:0] thr);
    longint nn [3][3];
    longint cc [3][3];
    longint dd [3];
    longint den;
    logic [127:0] aden, mag, dvd, quo;
    logic signed [127:0] num;
    logic signed [31:0] coord [3];
    bit neg, sat;
    int u, v;
    point_t r;
    r = '0;
    sat = 1'b0;
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) nn[p][k] = longint'($signed(w.nrm[p*3+k]));
      dd[p] = longint'($signed(w.dst[p]));
    end
    for (int p = 0; p < 3; p++) begin
      u = (p + 1) % 3;
      v = (p + 2) % 3;
      cc[p][0] = nn[u][1] * nn[v][2] - nn[u][2] * nn[v][1];
      cc[p][1] = nn[u][2] * nn[v][0] - nn[u][0] * nn[v][2];
      cc[p][2] = nn[u][0] * nn[v][1] - nn[u][1] * nn[v][0];
    end
    den = nn[0][0] * cc[0][0] + nn[0][1] * cc[0][1] + nn[0][2] * cc[0][2];
    aden = (den < 0) ? 128'(-den) : 128'(den);
    if (aden == 0 || aden < 128'(thr)) return r;
    for (int k = 0; k < 3; k++) begin
      num = '0;
      for (int p = 0; p < 3; p++) num += 128'(signed'(cc[p][k] * dd[p]));
      mag = (num < 0) ? 128'(-num) : 128'(num);
      dvd = mag << 14;
      quo = dvd / aden;
      neg = (num < 0) != (den < 0);
      if (neg) begin
        if (quo > 128'h8000_0000) begin
          sat = 1'b1;
          coord[k] = 32'sh8000_0000;
        end else begin
          coord[k] = 32'(-quo);
        end
      end else if (quo > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        coord[k] = 32'sh7FFF_FFFF;
      end else begin
        coord[k] = quo[31:0];
      end
    end
    r.x = coord[0];
    r.y = coord[1];
    r.z = coord[2];
    r.valid = 1'b1;
    r.sat = sat;
    return r;
  endfunction

  task automatic send_planes(planes_t w);
    if (idle_en && $urandom_range(99) < 14) begin
      repeat ($urandom_range(4, 1)) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    for (int i = 0; i < 9; i++) nrm_drv[i] <= w.nrm[i];
    for (int i = 0; i < 3; i++) dst_drv[i] <= w.dst[i];
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    point_q = {point_q, solve_planes(w, thr_model)};
  endtask

  task automatic drain_points();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (point_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic set_threshold(logic [42:0] thr);
    drain_points();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= thr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_model = thr;
  endtask

  function automatic planes_t make_planes(logic signed [15:0] a0, a1, a2, b0, b1, b2,
                                          c0, c1, c2, logic [31:0] da, db, dc);
    planes_t w;
    w.nrm = {c2, c1, c0, b2, b1, b0, a2, a1, a0};
    w.dst = {dc, db, da};
    return w;
  endfunction

  function automatic logic [15:0] rand_normal(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(32768)) - 16384);
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
    endcase
  endfunction

  function automatic planes_t rand_planes();
    planes_t w;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 9; i++) w.nrm[i] = rand_normal(mode);
    if ($urandom_range(9) == 0) begin
      // nearly parallel third plane
      for (int k = 0; k < 3; k++) w.nrm[6+k] = w.nrm[k] + 16'(int'($urandom_range(4)) - 2);
    end
    for (int p = 0; p < 3; p++)
      w.dst[p] = ($urandom_range(1)) ? 32'($urandom) : 32'(int'($urandom_range(8192)) - 4096);
    return w;
  endfunction

  task automatic test_directed();
    send_planes(make_planes(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 256, -512, 1024));
    send_planes(make_planes(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384,
                            32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_planes(make_planes(16384, 0, 0, 16384, 0, 0, 0, 0, 16384, 100, 200, 300));
    send_planes(make_planes(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_planes(make_planes(-32768, -32768, -32768, 32767, -32768, 32767,
                            -32768, 32767, 32767, 32'hFFFF_FFFF, 1, 32'h8000_0000));
    send_planes(make_planes(32767, 32767, 32767, -1, -1, -1, 32767, -32768, 0,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_planes(make_planes(16, 0, 0, 0, 16, 0, 0, 0, 16,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_planes(make_planes(1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 1));
    send_planes(make_planes(128, 0, 0, 0, 128, 0, 0, 0, 128, 1, -1, 2));
    send_planes(make_planes(16384, 16384, 0, 0, 16384, 16384, 16384, 0, 16384,
                            -32'sd1000, 32'sd5000, 32'sd77));
    send_planes(make_planes(2, 0, 0, 0, 2, 0, 0, 0, -2, 32'h8000_0000, 32'h8000_0000, 0));
  endtask

  task automatic test_threshold_zero();
    set_threshold('0);
    send_planes(make_planes(1, 0, 0, 0, 1, 0, 0, 0, 1, 32'h7FFF_FFFF, 5, -5));
    send_planes(make_planes(1, 2, 3, 2, 4, 6, 5, 1, 0, 10, 20, 30));
    send_planes(make_planes(1, 0, 0, 0, 1, 0, 0, 0, -1, 32'h8000_0000, 7, 32'h8000_0000));
  endtask

  task automatic test_threshold_max();
    set_threshold(THR_ALL);
    send_planes(make_planes(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 1, 2, 3));
    send_planes(make_planes(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 2, 3));
    set_threshold(43'h400_0000_0000);
    send_planes(make_planes(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 2, 3));
    send_planes(make_planes(-16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 2, 3));
  endtask

  task automatic test_random(int count);
    logic [42:0] thr;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 150) begin
        case ($urandom_range(3))
          0: thr = THR_RESET;
          1: thr = 43'($urandom_range(64));
          2: thr = {11'($urandom), 32'($urandom)};
          default: thr = 43'({$urandom, $urandom}) & 43'h3FF_FFFF;
        endcase
        set_threshold(thr);
      end
      idle_en = !(i >= 600 && i < 900);
      if (i == 1000) drain_points();
      send_planes(rand_planes());
    end
    idle_en = 1'b1;
  endtask

  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && done_o) begin
      got = '{point_x_o, point_y_o, point_z_o, point_valid_o, point_saturated_o};
      if (point_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = point_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_threshold_zero();
    test_threshold_max();
    set_threshold(THR_RESET);
    test_random(1750);
    drain_points();
    if (mismatches == 0 && point_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
